/* rtl/core/mpq_pkg.sv */
// ---------------------------------------------------------------------------
// mpq_pkg
// Shared sizes, codes and request/result types of the max priority queue.
// ---------------------------------------------------------------------------
`default_nettype none

package mpq_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int KID_W      = ADDR_W + 2;

    localparam logic [1:0] OP_ENQ  = 2'd0;
    localparam logic [1:0] OP_PEEK = 2'd1;
    localparam logic [1:0] OP_EXT  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic [1:0]                   operation;
        logic signed [DATA_WIDTH-1:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]                   status;
        logic signed [DATA_WIDTH-1:0] top_value;
        logic [CNT_W-1:0]             count;
    } t_res;

endpackage

`default_nettype wire

/* rtl/core/mpq_if.sv */
// ---------------------------------------------------------------------------
// mpq_if
// Valid/ready channels carrying queue requests and queue results.
// ---------------------------------------------------------------------------
`default_nettype none

interface mpq_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            operation;
    logic signed [mpq_pkg::DATA_WIDTH-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface mpq_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            status;
    logic signed [mpq_pkg::DATA_WIDTH-1:0] top_value;
    logic [mpq_pkg::CNT_W-1:0]             count;

    modport source (output valid, output status, output top_value, output count,
                    input ready);
    modport sink   (input valid, input status, input top_value, input count,
                    output ready);
endinterface

`default_nettype wire

/* rtl/core/mpq_heap.sv */
// ---------------------------------------------------------------------------
// mpq_heap
// Binary heap engine: element memory, root copy and sift sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module mpq_heap (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire mpq_pkg::t_req i_req,
    output logic               o_idle,
    output logic               o_res_valid,
    output mpq_pkg::t_res      o_res,
    input  wire logic          i_res_take
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_UP_RD    = 8'b0000_0010,
        S_UP_CMP   = 8'b0000_0100,
        S_LAST_RD  = 8'b0000_1000,
        S_LAST_CAP = 8'b0001_0000,
        S_DN_RD    = 8'b0010_0000,
        S_DN_CMP   = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_state;

    localparam int AW = mpq_pkg::ADDR_W;
    localparam int CW = mpq_pkg::CNT_W;
    localparam int KW = mpq_pkg::KID_W;
    localparam int DW = mpq_pkg::DATA_WIDTH;

    logic [DW-1:0] mem [mpq_pkg::DEPTH];

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_idx, n_idx;
    logic signed [DW-1:0]  r_val, n_val;
    logic signed [DW-1:0]  r_top;
    logic signed [DW-1:0]  r_res_top, n_res_top;
    logic [1:0]            r_status, n_status;
    logic                  r_use_root, n_use_root;
    logic                  r_has_r, n_has_r;
    logic signed [DW-1:0]  r_rd_a, r_rd_b;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DW-1:0]         wr_data;
    logic [AW-1:0]         rd_addr_a, rd_addr_b;
    logic [AW-1:0]         parent;
    logic [KW-1:0]         left, right, cnt_ext;
    logic signed [DW-1:0]  best;
    logic [KW-1:0]         best_idx;

    assign parent  = AW'((r_idx - AW'(1)) >> 1);
    assign left    = {1'b0, r_idx, 1'b1};
    assign right   = left + KW'(1);
    assign cnt_ext = KW'(r_count);

    always_comb begin
        if (r_has_r && (r_rd_b > r_rd_a)) begin
            best     = r_rd_b;
            best_idx = right;
        end else begin
            best     = r_rd_a;
            best_idx = left;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_val      = r_val;
        n_res_top  = r_res_top;
        n_status   = r_status;
        n_use_root = r_use_root;
        n_has_r    = r_has_r;
        wr_en      = 1'b0;
        wr_addr    = r_idx;
        wr_data    = r_val;
        rd_addr_a  = r_idx;
        rd_addr_b  = r_idx;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_status   = mpq_pkg::ST_OK;
                    n_use_root = 1'b1;
                    n_state    = S_DONE;
                    case (i_req.operation)
                        mpq_pkg::OP_ENQ: begin
                            if (r_count == CW'(mpq_pkg::DEPTH)) begin
                                n_status = mpq_pkg::ST_OVERFLOW;
                            end else begin
                                n_idx   = r_count[AW-1:0];
                                n_val   = i_req.value;
                                n_count = r_count + CW'(1);
                                n_state = S_UP_RD;
                            end
                        end
                        mpq_pkg::OP_EXT: begin
                            n_use_root = 1'b0;
                            if (r_count == '0) begin
                                n_status  = mpq_pkg::ST_UNDERFLOW;
                                n_res_top = '0;
                            end else begin
                                n_res_top = r_top;
                                n_count   = r_count - CW'(1);
                                if (r_count != CW'(1)) begin
                                    n_state = S_LAST_RD;
                                end
                            end
                        end
                        default: begin
                            // peek, and the spare code behaves as peek
                            if (r_count == '0) begin
                                n_status   = mpq_pkg::ST_UNDERFLOW;
                                n_use_root = 1'b0;
                                n_res_top  = '0;
                            end
                        end
                    endcase
                end
            end
            S_UP_RD: begin
                if (r_idx == '0) begin
                    wr_en   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    rd_addr_a = parent;
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                wr_en = 1'b1;
                if (r_val > r_rd_a) begin
                    // move parent down into the hole, climb one level
                    wr_data = r_rd_a;
                    n_idx   = parent;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LAST_RD: begin
                // count already decremented: it indexes the last element
                rd_addr_a = r_count[AW-1:0];
                n_idx     = '0;
                n_state   = S_LAST_CAP;
            end
            S_LAST_CAP: begin
                n_val   = r_rd_a;
                n_state = S_DN_RD;
            end
            S_DN_RD: begin
                if (left >= cnt_ext) begin
                    wr_en   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    rd_addr_a = left[AW-1:0];
                    rd_addr_b = right[AW-1:0];
                    n_has_r   = right < cnt_ext;
                    n_state   = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                wr_en = 1'b1;
                if (best > r_val) begin
                    wr_data = best;
                    n_idx   = best_idx[AW-1:0];
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_a <= mem[rd_addr_a];
        r_rd_b <= mem[rd_addr_b];
    end

    // root copy follows every write to entry zero
    always_ff @(posedge i_clk) begin
        if (wr_en && (wr_addr == '0)) begin
            r_top <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_val      <= n_val;
        r_res_top  <= n_res_top;
        r_status   <= n_status;
        r_use_root <= n_use_root;
        r_has_r    <= n_has_r;
    end

    assign o_idle          = (r_state == S_IDLE);
    assign o_res_valid     = (r_state == S_DONE);
    assign o_res.status    = r_status;
    assign o_res.top_value = r_use_root ? r_top : r_res_top;
    assign o_res.count     = r_count;

endmodule

`default_nettype wire

/* rtl/core/max_priority_queue_top.sv */
// ---------------------------------------------------------------------------
// max_priority_queue_top
// Max priority queue of signed values held as a binary heap in one RAM.
// ---------------------------------------------------------------------------
//  channel  | dir | payload                        | request accepted when
//  i_req    | in  | operation, value               | valid & ready
//  o_rsp    | out | status, top_value, count       | valid & ready
//
//  Peek, overflow, underflow and extract-to-empty go from idle straight to done, then to the output reg.
//  Enqueue sifts up, reading and comparing the parent per level climbed; extract reads and
//  captures the last element, then sifts down per level; one RAM read state per level.
//  One request at a time; the next is taken once the result sits in o_rsp.
//  Reset empties the queue at once; RAM contents are not cleared.
//  A stalled o_rsp holds one result; the engine then waits in its done state.
// ---------------------------------------------------------------------------
`default_nettype none

module max_priority_queue_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mpq_req_if.sink   i_req,
    mpq_rsp_if.source o_rsp
);

    mpq_pkg::t_req req;
    mpq_pkg::t_res res;
    mpq_pkg::t_res r_out;
    logic          r_out_valid;
    logic          idle;
    logic          res_valid;
    logic          res_take;
    logic          start;

    assign req.operation = i_req.operation;
    assign req.value     = i_req.value;
    assign i_req.ready   = idle;
    assign start         = i_req.valid & idle;
    assign res_take      = res_valid & (~r_out_valid | o_rsp.ready);

    mpq_heap u_heap (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (req),
        .o_idle      (idle),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out.status;
    assign o_rsp.top_value = r_out.top_value;
    assign o_rsp.count     = r_out.count;

endmodule

`default_nettype wire

/* rtl/core/mpq_checker.sv */
// ---------------------------------------------------------------------------
// mpq_checker
// Port-level checks of the max priority queue, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module mpq_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           i_in_ready,
    input wire logic                           i_out_valid,
    input wire logic                           i_out_ready,
    input wire logic [1:0]                     i_status,
    input wire logic [mpq_pkg::DATA_WIDTH-1:0] i_top_value,
    input wire logic [mpq_pkg::CNT_W-1:0]      i_count
);

    // one request in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request accepted while previous one still in progress");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_count <= mpq_pkg::CNT_W'(mpq_pkg::DEPTH)))
        else $error("count beyond depth");

    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == mpq_pkg::ST_UNDERFLOW))
            |-> ((i_count == '0) && (i_top_value == '0)))
        else $error("underflow with non-empty queue or non-zero top");

    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == mpq_pkg::ST_OVERFLOW))
            |-> (i_count == mpq_pkg::CNT_W'(mpq_pkg::DEPTH)))
        else $error("overflow reported on a queue that is not full");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready)
            |=> (i_out_valid && $stable(i_status) && $stable(i_top_value)
                 && $stable(i_count)))
        else $error("stalled result changed");

endmodule

bind max_priority_queue_top mpq_checker u_mpq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_top_value (o_rsp.top_value),
    .i_count     (o_rsp.count)
);

`default_nettype wire
